@@ rtl/tbad_pkg.sv @@
`timescale 1ns / 1ps

package tbad_pkg;

	// Timestamp bits in use and fixed field widths
	localparam int TIME_BITS     = 48;
	localparam int PORT_TIME_W   = 48;
	localparam int VAL_W         = 32;
	localparam int COUNT_W       = 16;
	localparam int WIDTH_W       = 32;
	localparam int MAX_BIN_COUNT = 65535;

	// Running sums hold up to MAX_BIN_COUNT terms without overflow
	localparam int TSUM_W = TIME_BITS + COUNT_W;
	localparam int VSUM_W = VAL_W + COUNT_W;

	// Bin end needs one bit beyond the wider of start and width
	localparam int END_W = ((TIME_BITS > WIDTH_W) ? TIME_BITS : WIDTH_W) + 1;

	// Shared divider register and step counter
	localparam int DIV_W  = (TSUM_W > VSUM_W) ? TSUM_W : VSUM_W;
	localparam int STEP_W = $clog2(DIV_W);

	localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = WIDTH_W'(1000);

	// Accumulator operations
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_FIRST,
		ACC_JOIN,
		ACC_NEXT,
		ACC_CLEAR
	} acc_op_t;

	typedef struct packed {
		acc_op_t op;
		logic    advance;
	} acc_cmd_t;

	typedef struct packed {
		logic open;
		logic before_end;
		logic full;
	} acc_stat_t;

	// Snapshot of the open bin handed to the divider
	typedef struct packed {
		logic [TSUM_W-1:0]        tsum;
		logic signed [VSUM_W-1:0] vsum;
		logic [COUNT_W-1:0]       count;
	} bin_t;

	typedef struct packed {
		logic [PORT_TIME_W-1:0]  mean_time;
		logic signed [VAL_W-1:0] mean_value;
		logic [COUNT_W-1:0]      samples;
	} res_t;

endpackage

@@ rtl/tbad_accum.sv @@
`timescale 1ns / 1ps

module tbad_accum (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tbad_pkg::WIDTH_W-1:0]     cfg_data,
	input  tbad_pkg::acc_cmd_t               cmd,
	input  logic [tbad_pkg::TIME_BITS-1:0]   t,
	input  logic signed [tbad_pkg::VAL_W-1:0] v,
	output tbad_pkg::acc_stat_t              stat,
	output tbad_pkg::bin_t                   bin
);
	import tbad_pkg::*;

	logic [WIDTH_W-1:0]        bin_width_q;
	logic                      series_open_q;
	logic [TIME_BITS-1:0]      bin_start_q;
	logic [TSUM_W-1:0]         time_sum_q;
	logic signed [VSUM_W-1:0]  value_sum_q;
	logic [COUNT_W-1:0]        count_q;

	logic [END_W-1:0]          bin_end;
	logic [TIME_BITS-1:0]      next_start;
	logic [TSUM_W-1:0]         t_ext;
	logic signed [VSUM_W-1:0]  v_ext;

	// Bin end and its saturated form for the next bin start
	assign bin_end = END_W'(bin_start_q) + END_W'(bin_width_q);
	assign next_start = (bin_end[END_W-1:TIME_BITS] != '0) ? {TIME_BITS{1'b1}}
		: bin_end[TIME_BITS-1:0];

	assign t_ext = TSUM_W'(t);
	assign v_ext = VSUM_W'(v);

	assign stat.open       = series_open_q;
	assign stat.before_end = END_W'(t) < bin_end;
	assign stat.full       = count_q >= COUNT_W'(MAX_BIN_COUNT);

	assign bin.tsum  = time_sum_q;
	assign bin.vsum  = value_sum_q;
	assign bin.count = count_q;

	// Hold the bin width register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_width_q <= BIN_WIDTH_RESET;
		end else if (cfg_we) begin
			bin_width_q <= cfg_data;
		end
	end

	// Open, extend, advance or clear the running bin
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_open_q <= 1'b0;
			bin_start_q   <= '0;
			time_sum_q    <= '0;
			value_sum_q   <= '0;
			count_q       <= '0;
		end else begin
			case (cmd.op)
				ACC_FIRST: begin
					series_open_q <= 1'b1;
					bin_start_q   <= t;
					time_sum_q    <= t_ext;
					value_sum_q   <= v_ext;
					count_q       <= COUNT_W'(1);
				end
				ACC_JOIN: begin
					time_sum_q  <= time_sum_q + t_ext;
					value_sum_q <= value_sum_q + v_ext;
					count_q     <= count_q + COUNT_W'(1);
				end
				ACC_NEXT: begin
					if (cmd.advance) begin
						bin_start_q <= next_start;
					end
					time_sum_q  <= t_ext;
					value_sum_q <= v_ext;
					count_q     <= COUNT_W'(1);
				end
				ACC_CLEAR: begin
					series_open_q <= 1'b0;
					time_sum_q    <= '0;
					value_sum_q   <= '0;
					count_q       <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	a_open_count: assert property (@(posedge clk) disable iff (!arst_n)
		series_open_q |-> count_q != '0)
		else $error("open bin holds no samples");

	a_closed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!series_open_q |-> (count_q == '0 && time_sum_q == '0))
		else $error("closed series left sums behind");

endmodule

@@ rtl/tbad_div.sv @@
`timescale 1ns / 1ps

module tbad_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tbad_pkg::bin_t  bin,
	output logic            done,
	output tbad_pkg::res_t  res
);
	import tbad_pkg::*;

	localparam int TSH = DIV_W - TSUM_W;
	localparam int VSH = DIV_W - VSUM_W;

	logic                 busy_q;
	logic                 done_q;
	logic                 phase_q;
	logic [STEP_W-1:0]    cnt_q;
	logic [DIV_W-1:0]     dq_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   d_q;
	logic                 neg_q;
	logic [VSUM_W-1:0]    vmag_q;
	logic [TIME_BITS-1:0] tq_q;

	logic                 neg;
	logic [VSUM_W-1:0]    vmag;
	logic [COUNT_W:0]     rem_sh;
	logic [COUNT_W:0]     diff;
	logic                 ge;
	logic [DIV_W-1:0]     dq_next;
	logic                 last_step;
	logic [VSUM_W-1:0]    vq;
	logic [VSUM_W-1:0]    vq_signed;

	// Magnitude of the value sum for unsigned division
	assign neg  = bin.vsum[VSUM_W-1];
	assign vmag = neg ? VSUM_W'(-bin.vsum) : VSUM_W'(bin.vsum);

	// One restoring step: shift in a dividend bit, subtract if it fits
	assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, d_q};
	assign diff    = rem_sh - {1'b0, d_q};
	assign dq_next = {dq_q[DIV_W-2:0], ge};
	assign last_step = phase_q ? (cnt_q == STEP_W'(VSUM_W - 1))
		: (cnt_q == STEP_W'(TSUM_W - 1));

	// Restore the sign of the value quotient
	assign vq        = dq_q[VSUM_W-1:0];
	assign vq_signed = neg_q ? -vq : vq;

	assign done           = done_q;
	assign res.mean_time  = PORT_TIME_W'(tq_q);
	assign res.mean_value = vq_signed[VAL_W-1:0];
	assign res.samples    = d_q;

	// Sequence time quotient, then value quotient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= '0;
			end else if (busy_q) begin
				if (last_step) begin
					cnt_q <= '0;
					if (phase_q) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						phase_q <= 1'b1;
					end
				end else begin
					cnt_q <= cnt_q + STEP_W'(1);
				end
			end
		end
	end

	// Dividend, remainder and captured operands
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= DIV_W'(bin.tsum) << TSH;
			rem_q  <= '0;
			d_q    <= (bin.count == '0) ? COUNT_W'(1) : bin.count;
			neg_q  <= neg;
			vmag_q <= vmag;
		end else if (busy_q) begin
			if (last_step && !phase_q) begin
				tq_q  <= dq_next[TIME_BITS-1:0];
				dq_q  <= DIV_W'(vmag_q) << VSH;
				rem_q <= '0;
			end else begin
				dq_q  <= dq_next;
				rem_q <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

@@ rtl/time_bin_average_decimator.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// in        sink       in_valid / in_stall       sample_time, sample_value, series_end
// out       source     out_valid / out_stall     mean_time, mean_value, bin_samples, last_point
// cfg       sink       cfg_valid / cfg_ready     cfg_data (bin_width)
//
// A sample that joins or opens a bin passes through accept (S_IDLE) and update (S_DECIDE).
// Each point emitted runs the shared restoring divider, one quotient bit per cycle:
// TIME_BITS+16 steps for the time mean and 48 for the value mean (112 at 48 bits),
// plus the emit, and a flush state ahead at series end; closing a bin and ending a series pays both.
// Reset clears the sequencer, bin state and output valid; bin_width returns to 1000.
// The result sits in an output register, so out_stall holds only that register; the
// sequencer waits to load it only when a new point is ready while it is full and out_stall is high.

module time_bin_average_decimator (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tbad_pkg::PORT_TIME_W-1:0]   sample_time,
	input  logic signed [tbad_pkg::VAL_W-1:0]  sample_value,
	input  logic                               series_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tbad_pkg::PORT_TIME_W-1:0]   mean_time,
	output logic signed [tbad_pkg::VAL_W-1:0]  mean_value,
	output logic [tbad_pkg::COUNT_W-1:0]       bin_samples,
	output logic                               last_point,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tbad_pkg::WIDTH_W-1:0]       cfg_data
);
	import tbad_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_FLUSH  = 5'b00100,
		S_DIV    = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t                  state_q;
	logic [TIME_BITS-1:0]    t_q;
	logic signed [VAL_W-1:0] v_q;
	logic                    end_q;
	logic                    last_q;

	logic                    out_valid_q;
	res_t                    out_q;
	logic                    out_last_q;

	logic                    in_accept;
	logic                    out_load;
	logic                    close_bin;
	logic                    div_start;
	logic                    div_done;
	acc_cmd_t                cmd;
	acc_stat_t               stat;
	bin_t                    bin;
	res_t                    res;

	assign in_stall  = state_q != S_IDLE;
	assign in_accept = in_valid && (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Close an open bin when the sample lies at or past the bin end or the bin is full
	assign close_bin = stat.open && (!stat.before_end || stat.full);
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign div_start = (state_q == S_FLUSH) || ((state_q == S_DECIDE) && close_bin);

	// Select the accumulator operation for this cycle
	always_comb begin
		cmd.op      = ACC_HOLD;
		cmd.advance = !stat.before_end;
		case (state_q)
			S_DECIDE: begin
				if (!stat.open) begin
					cmd.op = ACC_FIRST;
				end else if (close_bin) begin
					cmd.op = ACC_NEXT;
				end else begin
					cmd.op = ACC_JOIN;
				end
			end
			S_FLUSH: cmd.op = ACC_CLEAR;
			default: cmd.op = ACC_HOLD;
		endcase
	end

	tbad_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.t        (t_q),
		.v        (v_q),
		.stat     (stat),
		.bin      (bin)
	);

	tbad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.bin    (bin),
		.done   (div_done),
		.res    (res)
	);

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (close_bin) begin
						last_q  <= 1'b0;
						state_q <= S_DIV;
					end else if (end_q) begin
						state_q <= S_FLUSH;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					last_q  <= 1'b1;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_load) begin
						state_q <= (!last_q && end_q) ? S_FLUSH : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Hold the accepted sample
	always_ff @(posedge clk) begin
		if (in_accept) begin
			t_q   <= sample_time[TIME_BITS-1:0];
			v_q   <= sample_value;
			end_q <= series_end;
		end
	end

	// Output register: load a finished point, drop it on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= res;
			out_last_q <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign mean_time   = out_q.mean_time;
	assign mean_value  = out_q.mean_value;
	assign bin_samples = out_q.samples;
	assign last_point  = out_last_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && last_q) |=> state_q == S_IDLE)
		else $error("series end did not return to idle");

endmodule
